// ===== rtl/core/accpu_pkg.sv =====
// accpu_pkg: shared types and constants of the accumulator processor core
// opcodes, trap vectors, reset values and the result record
// no dependencies
`timescale 1ns / 1ps

package accpu_pkg;

  // parameter defaults
  localparam int unsigned MEM_DEPTH_DEF = 2048;
  localparam int unsigned WORD_BITS_DEF = 32;

  // fixed field widths
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned LOAD_ADDR_BITS = 11;
  localparam int unsigned RND_BITS = 7;
  localparam int unsigned LIMIT_BITS = 31;
  localparam int unsigned TIMER_BITS = 32;
  localparam int unsigned OP_BITS = 6;

  // reset values and vectors
  localparam int unsigned SYS_STACK_TOP = 2000;
  localparam int unsigned SYSCALL_VECTOR = 1500;
  localparam int unsigned TIMER_VECTOR = 1000;
  localparam int unsigned SP_RESET = 1000;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1000);

  // opcodes
  localparam logic [OP_BITS-1:0] OP_NONE  = 6'd0;
  localparam logic [OP_BITS-1:0] OP_LDI   = 6'd1;
  localparam logic [OP_BITS-1:0] OP_LDD   = 6'd2;
  localparam logic [OP_BITS-1:0] OP_LDII  = 6'd3;
  localparam logic [OP_BITS-1:0] OP_LDX   = 6'd4;
  localparam logic [OP_BITS-1:0] OP_LDY   = 6'd5;
  localparam logic [OP_BITS-1:0] OP_LDSPX = 6'd6;
  localparam logic [OP_BITS-1:0] OP_ST    = 6'd7;
  localparam logic [OP_BITS-1:0] OP_RND   = 6'd8;
  localparam logic [OP_BITS-1:0] OP_PRT   = 6'd9;
  localparam logic [OP_BITS-1:0] OP_ADDX  = 6'd10;
  localparam logic [OP_BITS-1:0] OP_ADDY  = 6'd11;
  localparam logic [OP_BITS-1:0] OP_SUBX  = 6'd12;
  localparam logic [OP_BITS-1:0] OP_SUBY  = 6'd13;
  localparam logic [OP_BITS-1:0] OP_ACX   = 6'd14;
  localparam logic [OP_BITS-1:0] OP_XAC   = 6'd15;
  localparam logic [OP_BITS-1:0] OP_ACY   = 6'd16;
  localparam logic [OP_BITS-1:0] OP_YAC   = 6'd17;
  localparam logic [OP_BITS-1:0] OP_ACSP  = 6'd18;
  localparam logic [OP_BITS-1:0] OP_SPAC  = 6'd19;
  localparam logic [OP_BITS-1:0] OP_JMP   = 6'd20;
  localparam logic [OP_BITS-1:0] OP_JZ    = 6'd21;
  localparam logic [OP_BITS-1:0] OP_JNZ   = 6'd22;
  localparam logic [OP_BITS-1:0] OP_CALL  = 6'd23;
  localparam logic [OP_BITS-1:0] OP_RET   = 6'd24;
  localparam logic [OP_BITS-1:0] OP_INCX  = 6'd25;
  localparam logic [OP_BITS-1:0] OP_DECX  = 6'd26;
  localparam logic [OP_BITS-1:0] OP_PUSH  = 6'd27;
  localparam logic [OP_BITS-1:0] OP_POP   = 6'd28;
  localparam logic [OP_BITS-1:0] OP_SYS   = 6'd29;
  localparam logic [OP_BITS-1:0] OP_IRET  = 6'd30;
  localparam logic [OP_BITS-1:0] OP_HALT  = 6'd50;

  // print operand codes
  localparam int unsigned PRT_INT = 1;
  localparam int unsigned PRT_CHAR = 2;

  // one result item
  typedef struct packed {
    logic                  print_valid;
    logic                  print_as_char;
    logic [FIELD_BITS-1:0] print_value;
    logic                  halted;
    logic                  bad_opcode;
    logic [FIELD_BITS-1:0] program_counter;
  } res_t;

endpackage

// ===== rtl/core/accpu_mem.sv =====
// accpu_mem: single-port word memory with registered read data
// depends on nothing but its parameters
`timescale 1ns / 1ps

module accpu_mem #(
  parameter int unsigned MEM_DEPTH = 2048,
  parameter int unsigned WORD_BITS = 32,
  localparam int unsigned ADDR_BITS = $clog2(MEM_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/accpu_seq.sv =====
// accpu_seq: instruction sequencer and register file of the processor
// drives the word memory one access per cycle; uses accpu_pkg
`timescale 1ns / 1ps

module accpu_seq
  import accpu_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  localparam int unsigned ADDR_BITS = $clog2(MEM_DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [LOAD_ADDR_BITS-1:0] load_address_i,
  input  logic signed [FIELD_BITS-1:0] load_data_i,
  input  logic [RND_BITS-1:0]       random_value_i,
  input  logic [LIMIT_BITS-1:0]     timer_limit_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output res_t                      res_o,
  output logic                      mem_we_o,
  output logic [ADDR_BITS-1:0]      mem_addr_o,
  output logic [WORD_BITS-1:0]      mem_wdata_o,
  input  logic [WORD_BITS-1:0]      mem_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_OPND,
    S_IND,
    S_LOADAC,
    S_STK,
    S_RTI2,
    S_TIMER,
    S_TRAP1,
    S_TRAP2,
    S_DONE
  } state_e;

  localparam int unsigned EXT_BITS = 64;

  state_e               state_q, state_d;
  logic [OP_BITS-1:0]   op_q, op_d;
  logic [WORD_BITS-1:0] pc_q, pc_d;
  logic [WORD_BITS-1:0] sp_q, sp_d;
  logic [WORD_BITS-1:0] ac_q, ac_d;
  logic [WORD_BITS-1:0] x_q, x_d;
  logic [WORD_BITS-1:0] y_q, y_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic                 kernel_q, kernel_d;
  logic                 stopped_q, stopped_d;
  logic                 trap_timer_q, trap_timer_d;
  logic [RND_BITS-1:0]  rnd_q, rnd_d;
  logic                 pv_q, pv_d;
  logic                 pchar_q, pchar_d;
  logic                 bad_q, bad_d;

  logic [WORD_BITS-1:0]  pc_inc, sp_inc, sp_dec;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic signed [EXT_BITS-1:0] load_ext;
  logic [EXT_BITS-1:0]   pc_ext, ac_ext;
  logic [OP_BITS-1:0]    op_dec;

  // word to memory address, depth is a power of two
  function automatic logic [ADDR_BITS-1:0] addr_of(input logic [WORD_BITS-1:0] w);
    return w[ADDR_BITS-1:0];
  endfunction

  assign pc_inc      = pc_q + 1'b1;
  assign sp_inc      = sp_q + 1'b1;
  assign sp_dec      = sp_q - 1'b1;
  assign elapsed_inc = elapsed_q + 1'b1;
  assign load_ext    = EXT_BITS'(load_data_i);
  assign pc_ext      = EXT_BITS'(pc_q);
  assign ac_ext      = EXT_BITS'(ac_q);
  assign op_dec      = (mem_rdata_i[WORD_BITS-1:OP_BITS] == '0) ?
                       mem_rdata_i[OP_BITS-1:0] : OP_NONE;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    pc_d         = pc_q;
    sp_d         = sp_q;
    ac_d         = ac_q;
    x_d          = x_q;
    y_d          = y_q;
    elapsed_d    = elapsed_q;
    kernel_d     = kernel_q;
    stopped_d    = stopped_q;
    trap_timer_d = trap_timer_q;
    rnd_d        = rnd_q;
    pv_d         = pv_q;
    pchar_d      = pchar_q;
    bad_d        = bad_q;
    mem_we_o     = 1'b0;
    mem_addr_o   = addr_of(pc_q);
    mem_wdata_o  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pv_d    = 1'b0;
          pchar_d = 1'b0;
          bad_d   = 1'b0;
          if (!kind_i) begin
            mem_we_o    = 1'b1;
            mem_addr_o  = ADDR_BITS'(load_address_i);
            mem_wdata_o = load_ext[WORD_BITS-1:0];
            state_d     = S_DONE;
          end else if (stopped_q) begin
            state_d = S_DONE;
          end else begin
            // fetch opcode
            rnd_d   = random_value_i;
            pc_d    = pc_inc;
            state_d = S_DECODE;
          end
        end
      end

      S_DECODE: begin
        op_d    = op_dec;
        state_d = S_TIMER;
        case (op_dec)
          OP_LDI, OP_LDD, OP_LDII, OP_LDX, OP_LDY, OP_ST, OP_PRT,
          OP_JMP, OP_JZ, OP_JNZ, OP_CALL: begin
            pc_d    = pc_inc;
            state_d = S_OPND;
          end
          OP_LDSPX: begin
            mem_addr_o = addr_of(sp_q + x_q);
            state_d    = S_LOADAC;
          end
          OP_RET, OP_POP, OP_IRET: begin
            mem_addr_o = addr_of(sp_q);
            state_d    = S_STK;
          end
          OP_PUSH: begin
            mem_we_o    = 1'b1;
            mem_addr_o  = addr_of(sp_dec);
            mem_wdata_o = ac_q;
            sp_d        = sp_dec;
          end
          OP_SYS: begin
            if (!kernel_q) begin
              trap_timer_d = 1'b0;
              state_d      = S_TRAP1;
            end
          end
          OP_RND:  ac_d = WORD_BITS'(rnd_q);
          OP_ADDX: ac_d = ac_q + x_q;
          OP_ADDY: ac_d = ac_q + y_q;
          OP_SUBX: ac_d = ac_q - x_q;
          OP_SUBY: ac_d = ac_q - y_q;
          OP_ACX:  x_d = ac_q;
          OP_XAC:  ac_d = x_q;
          OP_ACY:  y_d = ac_q;
          OP_YAC:  ac_d = y_q;
          OP_ACSP: sp_d = ac_q;
          OP_SPAC: ac_d = sp_q;
          OP_INCX: x_d = x_q + 1'b1;
          OP_DECX: x_d = x_q - 1'b1;
          OP_HALT: stopped_d = 1'b1;
          default: bad_d = 1'b1;
        endcase
      end

      S_OPND: begin
        state_d = S_TIMER;
        case (op_q)
          OP_LDI: ac_d = mem_rdata_i;
          OP_LDD: begin
            mem_addr_o = addr_of(mem_rdata_i);
            state_d    = S_LOADAC;
          end
          OP_LDII: begin
            mem_addr_o = addr_of(mem_rdata_i);
            state_d    = S_IND;
          end
          OP_LDX: begin
            mem_addr_o = addr_of(mem_rdata_i + x_q);
            state_d    = S_LOADAC;
          end
          OP_LDY: begin
            mem_addr_o = addr_of(mem_rdata_i + y_q);
            state_d    = S_LOADAC;
          end
          OP_ST: begin
            mem_we_o    = 1'b1;
            mem_addr_o  = addr_of(mem_rdata_i);
            mem_wdata_o = ac_q;
          end
          OP_PRT: begin
            if (mem_rdata_i == WORD_BITS'(PRT_INT)) begin
              pv_d = 1'b1;
            end else if (mem_rdata_i == WORD_BITS'(PRT_CHAR)) begin
              pv_d    = 1'b1;
              pchar_d = 1'b1;
            end
          end
          OP_JMP: pc_d = mem_rdata_i;
          OP_JZ: begin
            if (ac_q == '0) begin
              pc_d = mem_rdata_i;
            end
          end
          OP_JNZ: begin
            if (ac_q != '0) begin
              pc_d = mem_rdata_i;
            end
          end
          OP_CALL: begin
            mem_we_o    = 1'b1;
            mem_addr_o  = addr_of(sp_dec);
            mem_wdata_o = pc_q;
            sp_d        = sp_dec;
            pc_d        = mem_rdata_i;
          end
          default: state_d = S_TIMER;
        endcase
      end

      S_IND: begin
        mem_addr_o = addr_of(mem_rdata_i);
        state_d    = S_LOADAC;
      end

      S_LOADAC: begin
        ac_d    = mem_rdata_i;
        state_d = S_TIMER;
      end

      S_STK: begin
        state_d = S_TIMER;
        case (op_q)
          OP_RET: begin
            mem_we_o   = 1'b1;
            mem_addr_o = addr_of(sp_q);
            pc_d       = mem_rdata_i;
            sp_d       = sp_inc;
          end
          OP_POP: begin
            ac_d = mem_rdata_i;
            sp_d = sp_inc;
          end
          OP_IRET: begin
            mem_addr_o = addr_of(sp_inc);
            pc_d       = mem_rdata_i;
            sp_d       = sp_inc;
            state_d    = S_RTI2;
          end
          default: state_d = S_TIMER;
        endcase
      end

      S_RTI2: begin
        sp_d     = mem_rdata_i;
        kernel_d = 1'b0;
        state_d  = S_TIMER;
      end

      S_TIMER: begin
        elapsed_d = elapsed_inc;
        state_d   = S_DONE;
        if (({1'b0, timer_limit_i} <= elapsed_inc) && !kernel_q) begin
          elapsed_d    = elapsed_inc - {1'b0, timer_limit_i};
          trap_timer_d = 1'b1;
          state_d      = S_TRAP1;
        end
      end

      S_TRAP1: begin
        kernel_d    = 1'b1;
        mem_we_o    = 1'b1;
        mem_addr_o  = addr_of(WORD_BITS'(SYS_STACK_TOP - 1));
        mem_wdata_o = sp_q;
        sp_d        = WORD_BITS'(SYS_STACK_TOP - 1);
        state_d     = S_TRAP2;
      end

      S_TRAP2: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = addr_of(WORD_BITS'(SYS_STACK_TOP - 2));
        mem_wdata_o = pc_q;
        sp_d        = WORD_BITS'(SYS_STACK_TOP - 2);
        if (trap_timer_q) begin
          pc_d    = WORD_BITS'(TIMER_VECTOR);
          state_d = S_DONE;
        end else begin
          pc_d    = WORD_BITS'(SYSCALL_VECTOR);
          state_d = S_TIMER;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_NONE;
      pc_q         <= '0;
      sp_q         <= WORD_BITS'(SP_RESET);
      ac_q         <= '0;
      x_q          <= '0;
      y_q          <= '0;
      elapsed_q    <= '0;
      kernel_q     <= 1'b0;
      stopped_q    <= 1'b0;
      trap_timer_q <= 1'b0;
      pv_q         <= 1'b0;
      pchar_q      <= 1'b0;
      bad_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      pc_q         <= pc_d;
      sp_q         <= sp_d;
      ac_q         <= ac_d;
      x_q          <= x_d;
      y_q          <= y_d;
      elapsed_q    <= elapsed_d;
      kernel_q     <= kernel_d;
      stopped_q    <= stopped_d;
      trap_timer_q <= trap_timer_d;
      pv_q         <= pv_d;
      pchar_q      <= pchar_d;
      bad_q        <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.print_valid     = pv_q;
    res_o.print_as_char   = pchar_q;
    res_o.print_value     = pv_q ? ac_ext[FIELD_BITS-1:0] : '0;
    res_o.halted          = stopped_q;
    res_o.bad_opcode      = bad_q;
    res_o.program_counter = pc_ext[FIELD_BITS-1:0];
  end

  // a halted core answers an execute item without touching state
  a_halt_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && kind_i && stopped_q) |=> (state_q == S_DONE))
    else $error("halted execute item did not finish at once");

  // trap save leaves the core in kernel mode with the system stack two words below its top
  a_trap_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRAP2) |=> (kernel_q && sp_q == WORD_BITS'(SYS_STACK_TOP - 2)))
    else $error("trap save left wrong mode or stack pointer");

  // timer trap lands on the timer vector
  a_trap_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRAP2 && trap_timer_q) |=> (pc_q == WORD_BITS'(TIMER_VECTOR)))
    else $error("timer trap vector wrong");

  // a pending result holds until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("result changed before it was taken");

  // no memory write while waiting idle or on result handoff
  a_no_stray_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE || (state_q == S_IDLE && !in_valid_i)) |-> !mem_we_o)
    else $error("memory written outside an item");

endmodule

// ===== rtl/core/accumulator_cpu_with_timer_trap_core.sv =====
// accumulator_cpu_with_timer_trap_core: accumulator processor with a timer trap
// a load item writes its word and gives its result; an execute item steps through decode,
// each dependent access to the single-port word memory, the timer check and, on a trap,
// the two trap save writes; one item in work at a time, next accepted while a result waits
// reset: control state and timer limit reset at once; memory, result data not cleared
// uses accpu_pkg, accpu_seq, accpu_mem
`timescale 1ns / 1ps

module accumulator_cpu_with_timer_trap_core
  import accpu_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [LIMIT_BITS-1:0]     cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [LOAD_ADDR_BITS-1:0] load_address_i,
  input  logic signed [FIELD_BITS-1:0] load_data_i,
  input  logic [RND_BITS-1:0]       random_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      print_valid_o,
  output logic                      print_as_char_o,
  output logic signed [FIELD_BITS-1:0] print_value_o,
  output logic                      halted_o,
  output logic                      bad_opcode_o,
  output logic signed [FIELD_BITS-1:0] program_counter_o
);

  localparam int unsigned ADDR_BITS = $clog2(MEM_DEPTH);

  logic [LIMIT_BITS-1:0] limit_q;
  logic                  out_valid_q;
  res_t                  res_q;
  res_t                  seq_res;
  logic                  seq_res_valid;
  logic                  seq_res_ready;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_addr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [WORD_BITS-1:0]  mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  accpu_seq #(
    .MEM_DEPTH (MEM_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .load_address_i (load_address_i),
    .load_data_i    (load_data_i),
    .random_value_i (random_value_i),
    .timer_limit_i  (limit_q),
    .res_valid_o    (seq_res_valid),
    .res_ready_i    (seq_res_ready),
    .res_o          (seq_res),
    .mem_we_o       (mem_we),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata)
  );

  accpu_mem #(
    .MEM_DEPTH (MEM_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // output register
  assign seq_res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res_ready) begin
      out_valid_q <= seq_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_ready && seq_res_valid) begin
      res_q <= seq_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign print_valid_o     = res_q.print_valid;
  assign print_as_char_o   = res_q.print_as_char;
  assign print_value_o     = res_q.print_value;
  assign halted_o          = res_q.halted;
  assign bad_opcode_o      = res_q.bad_opcode;
  assign program_counter_o = res_q.program_counter;

endmodule

// ===== tb/sv/accumulator_cpu_with_timer_trap_core_checker.sv =====
// checker for the accumulator processor core: mirrors the timer limit register, predicts one
// result item per accepted input item and compares every accepted result field by field
// depends on accpu_pkg
`timescale 1ns / 1ps

module accumulator_cpu_with_timer_trap_core_checker
  import accpu_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [LIMIT_BITS-1:0]     cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      kind_i,
  input  logic [LOAD_ADDR_BITS-1:0] load_address_i,
  input  logic [FIELD_BITS-1:0]     load_data_i,
  input  logic [RND_BITS-1:0]       random_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      print_valid_i,
  input  logic                      print_as_char_i,
  input  logic [FIELD_BITS-1:0]     print_value_i,
  input  logic                      halted_i,
  input  logic                      bad_opcode_i,
  input  logic [FIELD_BITS-1:0]     program_counter_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               checked_o,
  output logic [FIELD_BITS-1:0]     cpu_pc_o,
  output logic                      cpu_kernel_o
);

  localparam int unsigned DEPTH = MEM_DEPTH_DEF;
  localparam logic KIND_LOAD = 1'b0;

  logic [FIELD_BITS-1:0] mem_words [DEPTH];
  logic [FIELD_BITS-1:0] cpu_pc, cpu_sp, cpu_ac, cpu_x, cpu_y, cpu_instr;
  logic [TIMER_BITS-1:0] cpu_elapsed;
  logic [LIMIT_BITS-1:0] cpu_limit;
  logic                  cpu_kernel, cpu_stopped;
  res_t                  step_results [$];
  int unsigned           fail_count, pending, checked;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign cpu_pc_o     = cpu_pc;
  assign cpu_kernel_o = cpu_kernel;

  function automatic logic [FIELD_BITS-1:0] read_word(input logic [FIELD_BITS-1:0] a);
    return mem_words[a % DEPTH];
  endfunction

  function automatic void write_word(input logic [FIELD_BITS-1:0] a,
                                     input logic [FIELD_BITS-1:0] v);
    mem_words[a % DEPTH] = v;
  endfunction

  function automatic logic [FIELD_BITS-1:0] fetch_word();
    logic [FIELD_BITS-1:0] v;
    v = read_word(cpu_pc);
    cpu_pc = cpu_pc + 1;
    return v;
  endfunction

  function automatic void push_word(input logic [FIELD_BITS-1:0] v);
    cpu_sp = cpu_sp - 1;
    write_word(cpu_sp, v);
  endfunction

  // save sp and pc on the system stack and jump to the vector
  function automatic void take_trap(input logic [FIELD_BITS-1:0] vector);
    logic [FIELD_BITS-1:0] old_sp;
    old_sp = cpu_sp;
    cpu_kernel = 1'b1;
    cpu_sp = SYS_STACK_TOP;
    push_word(old_sp);
    push_word(cpu_pc);
    cpu_pc = vector;
  endfunction

  task automatic step_cpu(input logic knd, input logic [LOAD_ADDR_BITS-1:0] addr,
                          input logic [FIELD_BITS-1:0] data, input logic [RND_BITS-1:0] rnd);
    res_t                  r;
    logic [FIELD_BITS-1:0] t;
    r = '0;
    if (knd == KIND_LOAD) begin
      write_word(FIELD_BITS'(addr), data);
    end else if (!cpu_stopped) begin
      cpu_instr = fetch_word();
      case (cpu_instr)
        OP_LDI:   cpu_ac = fetch_word();
        OP_LDD:   cpu_ac = read_word(fetch_word());
        OP_LDII:  cpu_ac = read_word(read_word(fetch_word()));
        OP_LDX:   cpu_ac = read_word(fetch_word() + cpu_x);
        OP_LDY:   cpu_ac = read_word(fetch_word() + cpu_y);
        OP_LDSPX: cpu_ac = read_word(cpu_sp + cpu_x);
        OP_ST:    write_word(fetch_word(), cpu_ac);
        OP_RND:   cpu_ac = FIELD_BITS'(rnd);
        OP_PRT: begin
          t = fetch_word();
          if (t == PRT_INT) begin
            r.print_valid = 1'b1;
          end else if (t == PRT_CHAR) begin
            r.print_valid = 1'b1;
            r.print_as_char = 1'b1;
          end
        end
        OP_ADDX:  cpu_ac = cpu_ac + cpu_x;
        OP_ADDY:  cpu_ac = cpu_ac + cpu_y;
        OP_SUBX:  cpu_ac = cpu_ac - cpu_x;
        OP_SUBY:  cpu_ac = cpu_ac - cpu_y;
        OP_ACX:   cpu_x = cpu_ac;
        OP_XAC:   cpu_ac = cpu_x;
        OP_ACY:   cpu_y = cpu_ac;
        OP_YAC:   cpu_ac = cpu_y;
        OP_ACSP:  cpu_sp = cpu_ac;
        OP_SPAC:  cpu_ac = cpu_sp;
        OP_JMP:   cpu_pc = fetch_word();
        OP_JZ: begin
          t = fetch_word();
          if (cpu_ac == 0) cpu_pc = t;
        end
        OP_JNZ: begin
          t = fetch_word();
          if (cpu_ac != 0) cpu_pc = t;
        end
        OP_CALL: begin
          t = fetch_word();
          push_word(cpu_pc);
          cpu_pc = t;
        end
        OP_RET: begin
          cpu_pc = read_word(cpu_sp);
          write_word(cpu_sp, '0);
          cpu_sp = cpu_sp + 1;
        end
        OP_INCX:  cpu_x = cpu_x + 1;
        OP_DECX:  cpu_x = cpu_x - 1;
        OP_PUSH:  push_word(cpu_ac);
        OP_POP: begin
          cpu_ac = read_word(cpu_sp);
          cpu_sp = cpu_sp + 1;
        end
        OP_SYS: begin
          if (!cpu_kernel) take_trap(SYSCALL_VECTOR);
        end
        OP_IRET: begin
          cpu_pc = read_word(cpu_sp);
          cpu_sp = cpu_sp + 1;
          cpu_sp = read_word(cpu_sp);
          cpu_kernel = 1'b0;
        end
        OP_HALT:  cpu_stopped = 1'b1;
        default:  r.bad_opcode = 1'b1;
      endcase
      cpu_elapsed = cpu_elapsed + 1;
      if (TIMER_BITS'(cpu_limit) <= cpu_elapsed && !cpu_kernel) begin
        cpu_elapsed = cpu_elapsed - TIMER_BITS'(cpu_limit);
        take_trap(TIMER_VECTOR);
      end
    end
    r.print_value = r.print_valid ? cpu_ac : '0;
    r.halted = cpu_stopped;
    r.program_counter = cpu_pc;
    step_results.push_back(r);
  endtask

  function automatic void compare_field(input string field, input logic [FIELD_BITS-1:0] want,
                                        input logic [FIELD_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
      fail_count++;
    end
  endfunction

  task automatic check_result();
    res_t want;
    if (step_results.size() == 0) begin
      $error("result item with no prediction pending, program_counter %0d",
             $signed(program_counter_i));
      fail_count++;
    end else begin
      want = step_results.pop_front();
      checked++;
      compare_field("print_valid", FIELD_BITS'(want.print_valid), FIELD_BITS'(print_valid_i));
      compare_field("print_as_char", FIELD_BITS'(want.print_as_char),
                    FIELD_BITS'(print_as_char_i));
      compare_field("print_value", want.print_value, print_value_i);
      compare_field("halted", FIELD_BITS'(want.halted), FIELD_BITS'(halted_i));
      compare_field("bad_opcode", FIELD_BITS'(want.bad_opcode), FIELD_BITS'(bad_opcode_i));
      compare_field("program_counter", want.program_counter, program_counter_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_pc = '0;
      cpu_sp = SP_RESET;
      cpu_ac = '0;
      cpu_x = '0;
      cpu_y = '0;
      cpu_instr = '0;
      cpu_elapsed = '0;
      cpu_limit = LIMIT_RESET;
      cpu_kernel = 1'b0;
      cpu_stopped = 1'b0;
      step_results.delete();
      fail_count = 0;
      pending = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) cpu_limit = cfg_wdata_i;
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) begin
        step_cpu(kind_i, load_address_i, load_data_i, random_value_i);
      end
      pending = step_results.size();
    end
  end

endmodule

// ===== tb/sv/accumulator_cpu_with_timer_trap_core_tb.sv =====
// testbench top for the accumulator processor core: clock, reset, memory fill, directed and
// random instruction items, timer limit writes, handshake idling and the verdict
// depends on accpu_pkg, accumulator_cpu_with_timer_trap_core and its checker
`timescale 1ns / 1ps

module accumulator_cpu_with_timer_trap_core_tb;
  import accpu_pkg::*;

  localparam logic        KIND_LOAD   = 1'b0;
  localparam logic        KIND_EXEC   = 1'b1;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [LIMIT_BITS-1:0]     cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      kind_i;
  logic [LOAD_ADDR_BITS-1:0] load_address_i;
  logic [FIELD_BITS-1:0]     load_data_i;
  logic [RND_BITS-1:0]       random_value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      print_valid_o;
  logic                      print_as_char_o;
  logic [FIELD_BITS-1:0]     print_value_o;
  logic                      halted_o;
  logic                      bad_opcode_o;
  logic [FIELD_BITS-1:0]     program_counter_o;

  int unsigned           fail_count, pending, checked;
  logic [FIELD_BITS-1:0] cpu_pc;
  logic                  cpu_kernel;

  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned items_sent, execs_sent, stall_cycles;
  bit          hold_req;

  accumulator_cpu_with_timer_trap_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .load_address_i    (load_address_i),
    .load_data_i       (load_data_i),
    .random_value_i    (random_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .print_valid_o     (print_valid_o),
    .print_as_char_o   (print_as_char_o),
    .print_value_o     (print_value_o),
    .halted_o          (halted_o),
    .bad_opcode_o      (bad_opcode_o),
    .program_counter_o (program_counter_o)
  );

  accumulator_cpu_with_timer_trap_core_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .kind_i            (kind_i),
    .load_address_i    (load_address_i),
    .load_data_i       (load_data_i),
    .random_value_i    (random_value_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .print_valid_i     (print_valid_o),
    .print_as_char_i   (print_as_char_o),
    .print_value_i     (print_value_o),
    .halted_i          (halted_o),
    .bad_opcode_i      (bad_opcode_o),
    .program_counter_i (program_counter_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked),
    .cpu_pc_o          (cpu_pc),
    .cpu_kernel_o      (cpu_kernel)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** accumulator_cpu_with_timer_trap_core: FAILED **");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the item is accepted
  task automatic send_item(input logic knd, input logic [LOAD_ADDR_BITS-1:0] addr,
                           input logic [FIELD_BITS-1:0] data, input logic [RND_BITS-1:0] rnd);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = knd;
    load_address_i = addr;
    load_data_i = data;
    random_value_i = rnd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    items_sent++;
    if (knd == KIND_EXEC) execs_sent++;
  endtask

  function automatic bit takes_operand(input logic [FIELD_BITS-1:0] op);
    case (op)
      OP_LDI, OP_LDD, OP_LDII, OP_LDX, OP_LDY, OP_ST, OP_PRT,
      OP_JMP, OP_JZ, OP_JNZ, OP_CALL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // place the instruction at the current pc, then execute it
  task automatic exec_op(input logic [FIELD_BITS-1:0] op, input logic [FIELD_BITS-1:0] operand,
                         input logic [RND_BITS-1:0] rnd);
    logic [LOAD_ADDR_BITS-1:0] at;
    at = cpu_pc[LOAD_ADDR_BITS-1:0];
    send_item(KIND_LOAD, at, op, RND_BITS'($urandom));
    if (takes_operand(op)) send_item(KIND_LOAD, at + 1'b1, operand, RND_BITS'($urandom));
    send_item(KIND_EXEC, LOAD_ADDR_BITS'($urandom), $urandom, rnd);
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_opcode(input logic kern);
    int unsigned roll;
    roll = $urandom_range(99);
    if (kern && roll < 25) return FIELD_BITS'(OP_IRET);
    roll = $urandom_range(99);
    if (roll < 5) begin
      case ($urandom_range(3))
        0: return FIELD_BITS'(OP_NONE);
        1: return FIELD_BITS'($urandom_range(31, 49));
        2: return FIELD_BITS'($urandom_range(51, 63));
        default: return $urandom;
      endcase
    end
    if (roll < 9) return FIELD_BITS'(OP_SYS);
    return FIELD_BITS'($urandom_range(1, 30));
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_operand(input logic [FIELD_BITS-1:0] op);
    case (op)
      OP_LDI: begin
        case ($urandom_range(3))
          0: return '0;
          1: return 32'h7fff_ffff;
          2: return 32'h8000_0000;
          default: return $urandom;
        endcase
      end
      OP_PRT: return ($urandom_range(9) == 0) ? $urandom : FIELD_BITS'($urandom_range(3));
      default: return ($urandom_range(7) == 0) ? $urandom : FIELD_BITS'($urandom_range(2047));
    endcase
  endfunction

  task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
    while (pending != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned           stop_at;
    logic [FIELD_BITS-1:0] op, operand;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 12) begin
        send_item(KIND_LOAD, LOAD_ADDR_BITS'($urandom), $urandom, RND_BITS'($urandom));
      end else begin
        op = pick_opcode(cpu_kernel);
        operand = pick_operand(op);
        // plant a pointer for the memory loads now and then
        if ((op == OP_LDII || op == OP_LDD) && $urandom_range(1) == 1) begin
          send_item(KIND_LOAD, operand[LOAD_ADDR_BITS-1:0], FIELD_BITS'($urandom_range(2047)),
                    RND_BITS'($urandom));
        end
        exec_op(op, operand, RND_BITS'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_LOAD;
    load_address_i = '0;
    load_data_i = '0;
    random_value_i = '0;
    hold_req = 1'b0;
    items_sent = 0;
    execs_sent = 0;
    stall_cycles = 0;
    send_idle_pct = 33;
    recv_idle_pct = 72;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every word written once so that no read finds an unwritten word
    for (int a = 0; a < MEM_DEPTH_DEF; a++) begin
      send_item(KIND_LOAD, LOAD_ADDR_BITS'(a), $urandom, RND_BITS'($urandom));
    end

    // directed, reset timer limit
    exec_op(OP_LDI, 32'h7fff_ffff, '0);
    exec_op(OP_ACX, '0, '0);
    exec_op(OP_LDI, 32'd1, '0);
    exec_op(OP_ADDX, '0, '0);
    exec_op(OP_PRT, PRT_INT, '0);
    exec_op(OP_PRT, PRT_CHAR, '0);
    exec_op(OP_PRT, 32'd3, '0);
    exec_op(OP_RND, '0, '0);
    exec_op(OP_RND, '0, '1);
    exec_op(OP_LDII, 32'hffff_ffff, '0);
    exec_op(OP_NONE, '0, '0);
    exec_op(32'h8000_0032, '0, '0);
    exec_op(OP_SYS, '0, '0);
    exec_op(OP_SYS, '0, '0);
    exec_op(OP_IRET, '0, '0);

    write_limit(LIMIT_BITS'(1));
    run_random(350);
    write_limit(LIMIT_BITS'(7));
    run_random(350);

    send_idle_pct = 72;
    recv_idle_pct = 33;
    write_limit(LIMIT_MAX);
    run_random(350);
    write_limit('0);
    run_random(350);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(LIMIT_BITS'(25));
    run_random(250);
    hold_req = 1'b1;
    run_random(250);
    write_limit(LIMIT_RESET);
    run_random(200);

    // halt, then executes that do nothing and a load that still writes
    exec_op(OP_HALT, '0, RND_BITS'($urandom));
    exec_op(OP_LDI, 32'h1234, '0);
    send_item(KIND_LOAD, LOAD_ADDR_BITS'($urandom), $urandom, RND_BITS'($urandom));
    send_item(KIND_EXEC, LOAD_ADDR_BITS'($urandom), $urandom, RND_BITS'($urandom));

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("ran %0d items (%0d instructions, rest memory loads), %0d results compared",
             items_sent, execs_sent, checked);
    $display("timer limits 0, 1, 7, 25, 1000 and max, with traps, syscalls and halt");
    if (fail_count == 0 && pending == 0) begin
      $display("** accumulator_cpu_with_timer_trap_core: PASSED **");
    end else begin
      $display("** accumulator_cpu_with_timer_trap_core: FAILED **");
    end
    $finish;
  end

endmodule
